### rtl/mcs_pkg.sv
// Shared types and constants for the min-max contrast stretch block.
package mcs_pkg;

  localparam int PIXEL_BITS = 8;
  localparam int CHANNELS   = 3;

  // Working widths: signed differences and products, unsigned quotients.
  localparam int DIFF_W = PIXEL_BITS + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int QUO_W  = 2 * PIXEL_BITS;

  // Divider retires RADIX_BITS quotient bits per step.
  localparam int RADIX_BITS = 2;
  localparam int DIV_STEPS  = QUO_W / RADIX_BITS;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  // Configuration register map.
  localparam int ADDR_W    = 3;
  localparam int REG_IDX_W = ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_NEW_MAX = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_NEW_MIN = 1'b1;

  typedef logic [PIXEL_BITS-1:0] pix_t;

  localparam pix_t PIX_MAX     = '1;
  localparam pix_t RST_NEW_MAX = '1;
  localparam pix_t RST_NEW_MIN = '0;

  typedef struct packed {
    logic start;
    logic step;
  } div_ctrl_t;

endpackage

### rtl/mcs_stats.sv
// Running per-channel minimum and maximum statistics.
module mcs_stats
  import mcs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 update,
  input  logic                 restart,
  input  pix_t [CHANNELS-1:0]  pix,
  output pix_t [CHANNELS-1:0]  ch_min,
  output pix_t [CHANNELS-1:0]  ch_max
);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < CHANNELS; k++) begin
        ch_min[k] <= PIX_MAX;
        ch_max[k] <= '0;
      end
    end else if (update) begin
      for (int k = 0; k < CHANNELS; k++) begin
        if (restart) begin
          ch_min[k] <= pix[k];
          ch_max[k] <= pix[k];
        end else begin
          if (pix[k] < ch_min[k]) ch_min[k] <= pix[k];
          if (pix[k] > ch_max[k]) ch_max[k] <= pix[k];
        end
      end
    end
  end

endmodule

### rtl/mcs_div.sv
// Iterative unsigned divider, restoring, RADIX_BITS quotient bits per step.
module mcs_div
  import mcs_pkg::*;
(
  input  logic             clk,
  input  div_ctrl_t        ctrl,
  input  logic [QUO_W-1:0] dividend,
  input  pix_t             divisor,
  output logic [QUO_W-1:0] quotient
);

  pix_t             rem;
  pix_t             dvs;
  logic [QUO_W-1:0] quo;
  pix_t             rem_next;
  logic [QUO_W-1:0] quo_next;

  // Two dependent shift-subtract steps per cycle, applied when ctrl.step is high.
  always_comb begin
    logic [PIXEL_BITS:0] trial;
    logic [QUO_W-1:0]    q;
    pix_t                r;
    r = rem;
    q = quo;
    for (int i = 0; i < RADIX_BITS; i++) begin
      trial = {r, q[QUO_W-1]};
      q     = {q[QUO_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs}) begin
        trial = trial - {1'b0, dvs};
        q[0]  = 1'b1;
      end
      r = trial[PIXEL_BITS-1:0];
    end
    rem_next = r;
    quo_next = q;
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (ctrl.step) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  assign quotient = quo;

endmodule

### rtl/min_max_contrast_stretch.sv
// Top level of the min-max contrast stretch: registers, sequencer, lanes, result register.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one pixel per beat with mode and
//   frame_start. A measure beat (mode 0) folds the pixel into per-channel min and
//   max and yields no result; frame_start on a measure beat restarts the statistics.
//   A map beat (mode 1) yields one result beat on the output channel
//   (out_valid / out_stall) with the stretched channels and the flat flags.
//   Map path: multiply state, then 8 divide steps of 2 quotient bits each in the
//   per-channel divider lanes, then the finishing state, where the result loads
//   and out_valid rises. Throughput: measure, one pixel per cycle while in_stall
//   is low; map, in_stall is high from acceptance until the result loads.
//   The result sits in an output register, so input beats are taken while a
//   result waits; a map pixel that finishes while the receiver stalls holds in
//   its finishing state until the register frees up.
//   new_max (0x0) and new_min (0x4) sit on the APB port; write them only while
//   idle. Synchronous reset gives new_max 255, new_min 0, min 255, max 0 and an
//   empty output register.
module min_max_contrast_stretch
  import mcs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // pixel channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              mode,
  input  logic              frame_start,
  input  pix_t              red_in,
  input  pix_t              green_in,
  input  pix_t              blue_in,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output pix_t              red_out,
  output pix_t              green_out,
  output pix_t              blue_out,
  output logic [CHANNELS-1:0] flat_channels,
  // APB configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]           state;
  logic [1:0]           state_next;
  logic [STEP_W-1:0]    step_cnt;

  pix_t                 new_max;
  pix_t                 new_min;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;

  logic                 in_acc;
  logic                 out_acc;
  logic                 out_load;
  pix_t [CHANNELS-1:0]  in_pix;
  pix_t [CHANNELS-1:0]  pix;       // captured map pixel
  pix_t [CHANNELS-1:0]  ch_min;
  pix_t [CHANNELS-1:0]  ch_max;
  pix_t [CHANNELS-1:0]  mapped;
  logic [CHANNELS-1:0]  flat;
  logic [CHANNELS-1:0]  neg;
  div_ctrl_t            div_ctrl;

  // ---------------------------------------------------------------- config port
  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      new_max <= RST_NEW_MAX;
      new_min <= RST_NEW_MIN;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_NEW_MAX: new_max <= pwdata[PIXEL_BITS-1:0];
        REG_NEW_MIN: new_min <= pwdata[PIXEL_BITS-1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_NEW_MAX: prdata = 32'(new_max);
      REG_NEW_MIN: prdata = 32'(new_min);
      default:     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- handshakes
  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid & ~in_stall;
  assign out_acc  = out_valid & ~out_stall;
  // the result register frees up on the same edge its beat is taken
  assign out_load = (state == ST_DONE) & (~out_valid | ~out_stall);
  assign in_pix   = {blue_in, green_in, red_in};

  // ---------------------------------------------------------------- statistics
  mcs_stats u_stats (
    .clk     (clk),
    .rst     (rst),
    .update  (in_acc & ~mode),
    .restart (frame_start),
    .pix     (in_pix),
    .ch_min  (ch_min),
    .ch_max  (ch_max)
  );

  always_ff @(posedge clk) begin
    if (in_acc && mode) pix <= in_pix;
  end

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_acc && mode) state_next = ST_MUL;
      ST_MUL:  state_next = ST_DIV;
      ST_DIV:  if (step_cnt == STEP_W'(DIV_STEPS - 1)) state_next = ST_DONE;
      ST_DONE: if (out_load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_DIV) step_cnt <= step_cnt + 1'b1;
      else                 step_cnt <= '0;
    end
  end

  assign div_ctrl.start = (state == ST_MUL);
  assign div_ctrl.step  = (state == ST_DIV);

  // ---------------------------------------------------------------- lanes
  // Per channel: (pix - min) * (new_max - new_min) in the multiply cycle, the
  // magnitudes go to the divider, the signs are recombined at the end.
  for (genvar k = 0; k < CHANNELS; k++) begin : g_lane
    logic signed [DIFF_W-1:0] diff;
    logic signed [DIFF_W-1:0] tdelta;
    logic signed [DIFF_W-1:0] sdelta;
    logic signed [PROD_W-1:0] prod;
    logic [QUO_W-1:0]         prod_mag;
    pix_t                     sdelta_mag;
    logic [QUO_W-1:0]         quo;
    logic signed [PROD_W-1:0] quo_s;
    logic signed [PROD_W-1:0] val;

    assign diff   = $signed({1'b0, pix[k]}) - $signed({1'b0, ch_min[k]});
    assign tdelta = $signed({1'b0, new_max}) - $signed({1'b0, new_min});
    assign sdelta = $signed({1'b0, ch_max[k]}) - $signed({1'b0, ch_min[k]});
    assign prod   = PROD_W'(diff) * PROD_W'(tdelta);

    assign prod_mag = prod[PROD_W-1] ? QUO_W'(-prod) : prod[QUO_W-1:0];
    // a flat channel never uses the quotient; keep the divisor non-zero
    assign sdelta_mag = (sdelta == '0) ? pix_t'(1) :
                        sdelta[DIFF_W-1] ? PIXEL_BITS'(-sdelta) : sdelta[PIXEL_BITS-1:0];

    always_ff @(posedge clk) begin
      if (state == ST_MUL) begin
        flat[k] <= (sdelta == '0);
        neg[k]  <= prod[PROD_W-1] ^ sdelta[DIFF_W-1];
      end
    end

    mcs_div u_div (
      .clk      (clk),
      .ctrl     (div_ctrl),
      .dividend (prod_mag),
      .divisor  (sdelta_mag),
      .quotient (quo)
    );

    // truncation toward zero: divide magnitudes, then apply the sign
    assign quo_s = neg[k] ? -$signed(PROD_W'(quo)) : $signed(PROD_W'(quo));
    assign val   = flat[k] ? $signed(PROD_W'(new_min))
                           : quo_s + $signed(PROD_W'(new_min));

    always_comb begin
      if (val < 0)                          mapped[k] = '0;
      else if (val > $signed(PROD_W'(PIX_MAX))) mapped[k] = PIX_MAX;
      else                                  mapped[k] = val[PIXEL_BITS-1:0];
    end
  end

  // ---------------------------------------------------------------- result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_acc) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      red_out       <= mapped[0];
      green_out     <= mapped[1];
      blue_out      <= mapped[2];
      flat_channels <= flat;
    end
  end

endmodule
